>>> hdl/sms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and constants for the switch matrix scanner.
// ----------------------------------------------------------------------------
package sms_pkg;

    localparam int ROWS_DEFAULT = 8;
    localparam int COLS_DEFAULT = 8;
    localparam int ROW_IDX_W    = 3;
    localparam int COL_W        = 8;
    localparam int TICK_W       = 16;
    localparam int CNT_W        = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [TICK_W-1:0] SETTLE_RESET  = 16'd5;
    localparam logic [TICK_W-1:0] HOLD_RESET    = 16'd10;
    localparam logic [CNT_W-1:0]  SAMPLES_RESET = 4'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETTLE  = 2'd0,
        CFG_HOLD    = 2'd1,
        CFG_SAMPLES = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_SETTLE = 2'd0,
        PH_SAMPLE = 2'd1,
        PH_HOLD   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0] settle_ticks;
        logic [TICK_W-1:0] hold_ticks;
        logic [CNT_W-1:0]  vote_samples;
    } cfg_t;

    // What one tick of the sequencer hands to the frame store.
    typedef struct packed {
        logic                 finish;
        logic [ROW_IDX_W-1:0] row;
        logic [COL_W-1:0]     bits;
    } step_t;

endpackage

>>> hdl/sms_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_sequencer
// Row sequencer: settle, sample and hold phases, per-column high counters
// and the majority vote for the row that finishes.
// ----------------------------------------------------------------------------
module sms_sequencer #(
    parameter int ROWS = sms_pkg::ROWS_DEFAULT,
    parameter int COLS = sms_pkg::COLS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [sms_pkg::COL_W-1:0]    col_levels,
    input  sms_pkg::cfg_t                cfg,
    output sms_pkg::step_t               step
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int CW    = sms_pkg::CNT_W;

    logic [ROW_W-1:0]              row_reg, row_next;
    sms_pkg::phase_t               phase_reg, phase_next;
    logic [sms_pkg::TICK_W-1:0]    timer_reg, timer_next;
    logic [CW-1:0]                 samples_reg, samples_next;
    logic [COLS-1:0][CW-1:0]       counts_reg, counts_next;
    logic [COLS-1:0][CW-1:0]       counts_upd;
    logic                          sampling;
    logic                          finish;
    logic [CW-1:0]                 target;
    logic [sms_pkg::COL_W-1:0]     vote_bits;

    assign target = (cfg.vote_samples == '0) ? CW'(1) : cfg.vote_samples;

    always_comb
    begin
        for (int c = 0; c < COLS; c++)
        begin
            counts_upd[c] = counts_reg[c] + CW'(col_levels[c]);
        end
    end

    // Next state for one tick.
    always_comb
    begin
        row_next     = row_reg;
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        samples_next = samples_reg;
        counts_next  = counts_reg;
        sampling     = 1'b0;
        finish       = 1'b0;
        unique case (phase_reg)
            sms_pkg::PH_HOLD:
            begin
                if (timer_reg < cfg.hold_ticks)
                begin
                    timer_next = timer_reg + 1'b1;
                end
                if (timer_next >= cfg.hold_ticks)
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                sampling = (phase_reg == sms_pkg::PH_SAMPLE);
                if (!sampling)
                begin
                    if (timer_reg < cfg.settle_ticks)
                    begin
                        timer_next = timer_reg + 1'b1;
                    end
                    else
                    begin
                        sampling   = 1'b1;
                        timer_next = '0;
                    end
                end
                if (sampling)
                begin
                    // Samples are still zero on the tick the settle phase ends.
                    phase_next   = sms_pkg::PH_SAMPLE;
                    counts_next  = counts_upd;
                    samples_next = samples_reg + 1'b1;
                    if (samples_next >= target)
                    begin
                        if (cfg.hold_ticks > cfg.settle_ticks)
                        begin
                            phase_next = sms_pkg::PH_HOLD;
                            timer_next = '0;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                end
            end
        endcase
        if (finish)
        begin
            row_next     = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + 1'b1;
            phase_next   = sms_pkg::PH_SETTLE;
            timer_next   = '0;
            samples_next = '0;
            counts_next  = '0;
        end
    end

    // Majority vote over the counts as they stand after this tick.
    always_comb
    begin
        vote_bits = '0;
        if (sampling)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                vote_bits[c] = counts_upd[c] > (target >> 1);
            end
        end
        else
        begin
            for (int c = 0; c < COLS; c++)
            begin
                vote_bits[c] = counts_reg[c] > (target >> 1);
            end
        end
    end

    assign step.finish = finish;
    assign step.row    = sms_pkg::ROW_IDX_W'(row_reg);
    assign step.bits   = vote_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            phase_reg   <= sms_pkg::PH_SETTLE;
            timer_reg   <= '0;
            samples_reg <= '0;
            counts_reg  <= '0;
        end
        else if (accept)
        begin
            row_reg     <= row_next;
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            samples_reg <= samples_next;
            counts_reg  <= counts_next;
        end
    end

    // Counters are clear whenever a row is still settling.
    a_settle_counts_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sms_pkg::PH_SETTLE |-> counts_reg == '0 && samples_reg == '0)
        else $error("counters not clear in settle phase");

    a_finish_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && finish |=> phase_reg == sms_pkg::PH_SETTLE && timer_reg == '0)
        else $error("finished row did not restart in settle phase");

    a_row_advances: assert property (@(posedge clk) disable iff (!rst_n)
        accept && finish |=> row_reg != $past(row_reg))
        else $error("scan row did not advance after a finished row");

    a_row_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !finish |=> row_reg == $past(row_reg))
        else $error("scan row moved without a finished row");

endmodule

>>> hdl/sms_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_frame
// Frame store and result register: stores changed rows and presents one
// result beat per accepted tick.
// ----------------------------------------------------------------------------
module sms_frame #(
    parameter int ROWS = sms_pkg::ROWS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  sms_pkg::step_t                  step,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [sms_pkg::ROW_IDX_W-1:0]   row_index,
    output logic                            frame_changed,
    output logic [sms_pkg::ROW_IDX_W-1:0]   changed_row,
    output logic [8*sms_pkg::COL_W-1:0]     frame,
    output logic                            frame_complete
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int CW    = sms_pkg::COL_W;

    logic [ROWS-1:0][CW-1:0]            store_reg;
    logic                               valid_reg;
    logic [sms_pkg::ROW_IDX_W-1:0]      row_index_reg;
    logic                               changed_reg;
    logic [sms_pkg::ROW_IDX_W-1:0]      changed_row_reg;
    logic                               complete_reg;
    logic [ROW_W-1:0]                   widx;
    logic                               differs;
    logic                               last_row;

    assign widx     = step.row[ROW_W-1:0];
    assign differs  = step.finish && (store_reg[widx] != step.bits);
    assign last_row = step.finish && (widx == ROW_W'(ROWS - 1));

    // The store only moves on an accepted tick, so it matches the held beat.
    always_comb
    begin
        frame = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            frame[CW*r +: CW] = store_reg[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                valid_reg <= 1'b1;
                if (differs)
                begin
                    store_reg[widx] <= step.bits;
                end
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_index_reg   <= step.row;
            changed_reg     <= differs;
            changed_row_reg <= differs ? step.row : '0;
            complete_reg    <= last_row;
        end
    end

    assign out_valid      = valid_reg;
    assign row_index      = row_index_reg;
    assign frame_changed  = changed_reg;
    assign changed_row    = changed_row_reg;
    assign frame_complete = complete_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_stall |-> !accept)
        else $error("tick accepted while a result beat was stalled");

    a_change_stored: assert property (@(posedge clk) disable iff (!rst_n)
        accept && differs |=> store_reg[$past(widx)] == $past(step.bits))
        else $error("changed row was not written to the frame store");

endmodule

>>> hdl/switch_matrix_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// switch_matrix_scanner
// Row-by-row scanner with majority debounce for an active-high switch matrix.
// ----------------------------------------------------------------------------
// One tick of column levels is taken on every clock in which the result
// register is free or being emptied; its beat appears in the next clock, so
// the scanner sustains one tick per clock unless the output stalls. The
// sequencer and the frame store both update in the accepting cycle; the result
// register is the only stage between input and output, and a stall on the
// output holds the input back in the same cycle. The frame store is flip-flops
// cleared by reset, with no clearing pass. Config writes are always ready.
// ----------------------------------------------------------------------------
module switch_matrix_scanner #(
    parameter int ROWS = sms_pkg::ROWS_DEFAULT,
    parameter int COLS = sms_pkg::COLS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sms_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [sms_pkg::COL_W-1:0]         col_levels,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sms_pkg::ROW_IDX_W-1:0]     row_index,
    output logic                              row_active,
    output logic                              frame_changed,
    output logic [sms_pkg::ROW_IDX_W-1:0]     changed_row,
    output logic [8*sms_pkg::COL_W-1:0]       frame,
    output logic                              frame_complete
);

    sms_pkg::cfg_t   cfg_reg;
    sms_pkg::step_t  step;
    logic            accept;

    assign cfg_ready  = 1'b1;
    assign in_stall   = out_valid && out_stall;
    assign accept     = in_valid && !in_stall;
    assign row_active = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ticks <= sms_pkg::SETTLE_RESET;
            cfg_reg.hold_ticks   <= sms_pkg::HOLD_RESET;
            cfg_reg.vote_samples <= sms_pkg::SAMPLES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sms_pkg::CFG_SETTLE:  cfg_reg.settle_ticks <= cfg_data;
                sms_pkg::CFG_HOLD:    cfg_reg.hold_ticks   <= cfg_data;
                sms_pkg::CFG_SAMPLES: cfg_reg.vote_samples <= cfg_data[sms_pkg::CNT_W-1:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    sms_sequencer #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_sequencer (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .col_levels (col_levels),
        .cfg        (cfg_reg),
        .step       (step)
    );

    sms_frame #(
        .ROWS (ROWS)
    ) u_frame (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .step           (step),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .row_index      (row_index),
        .frame_changed  (frame_changed),
        .changed_row    (changed_row),
        .frame          (frame),
        .frame_complete (frame_complete)
    );

endmodule

>>> test/switch_matrix_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// switch_matrix_scanner_tb
// Self-checking bench for the switch matrix scanner. A tracker class keeps its
// own copy of the scan sequencer, debounce counters and frame store, predicts
// one result beat per accepted tick of column levels and checks every result
// beat field by field. Stimulus runs a short directed part, then segments of
// noisy switch patterns under several timing settings and idle mixes.
// ----------------------------------------------------------------------------
module switch_matrix_scanner_tb;

    localparam int ROW_LAST = sms_pkg::ROWS_DEFAULT - 1;
    // Register index with no register behind it; writes to it must do nothing.
    localparam logic [sms_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SEGMENTS     = 9;
    localparam int SEG_TICKS    = 55;
    localparam int PRESSURE_SEG = 6;
    localparam int HOLD_OFF_CYCLES = 40;

    typedef struct packed {
        logic [sms_pkg::ROW_IDX_W-1:0] row_index;
        logic                          row_active;
        logic                          frame_changed;
        logic [sms_pkg::ROW_IDX_W-1:0] changed_row;
        logic [8*sms_pkg::COL_W-1:0]   frame;
        logic                          frame_complete;
    } scan_beat_t;

    class frame_tracker;
        logic [sms_pkg::TICK_W-1:0]    settle_ticks;
        logic [sms_pkg::TICK_W-1:0]    hold_ticks;
        logic [sms_pkg::CNT_W-1:0]     vote_samples;
        logic [sms_pkg::ROW_IDX_W-1:0] scan_row;
        sms_pkg::phase_t               phase;
        logic [sms_pkg::TICK_W-1:0]    phase_timer;
        logic [sms_pkg::CNT_W-1:0]     samples_taken;
        logic [sms_pkg::CNT_W-1:0]     high_counts [sms_pkg::COL_W];
        logic [sms_pkg::COL_W-1:0]     stored_rows [sms_pkg::ROWS_DEFAULT];
        scan_beat_t                    expected_beats [$];
        int                            mismatches;
        int                            beats_seen;

        function new();
            settle_ticks  = sms_pkg::SETTLE_RESET;
            hold_ticks    = sms_pkg::HOLD_RESET;
            vote_samples  = sms_pkg::SAMPLES_RESET;
            scan_row      = '0;
            phase         = sms_pkg::PH_SETTLE;
            phase_timer   = '0;
            samples_taken = '0;
            for (int c = 0; c < sms_pkg::COL_W; c++)
                high_counts[c] = '0;
            for (int r = 0; r < sms_pkg::ROWS_DEFAULT; r++)
                stored_rows[r] = '0;
            mismatches = 0;
            beats_seen = 0;
        endfunction

        function void set_reg(logic [sms_pkg::CFG_IDX_W-1:0] idx,
                              logic [sms_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                sms_pkg::CFG_SETTLE:  settle_ticks = data;
                sms_pkg::CFG_HOLD:    hold_ticks = data;
                sms_pkg::CFG_SAMPLES: vote_samples = data[sms_pkg::CNT_W-1:0];
                default:              ;
            endcase
        endfunction

        // Advances the scanner by one tick and queues the beat it must produce.
        function void note_tick(logic [sms_pkg::COL_W-1:0] levels);
            scan_beat_t                beat;
            logic                      finish;
            logic [sms_pkg::CNT_W-1:0] target;
            logic [sms_pkg::COL_W-1:0] voted;
            beat   = '0;
            finish = 1'b0;
            target = (vote_samples == '0) ? 4'd1 : vote_samples;
            if (phase == sms_pkg::PH_HOLD)
            begin
                if (phase_timer < hold_ticks)
                    phase_timer = phase_timer + 1'b1;
                if (phase_timer >= hold_ticks)
                    finish = 1'b1;
            end
            else
            begin
                if (phase != sms_pkg::PH_SAMPLE)
                begin
                    if (phase_timer < settle_ticks)
                        phase_timer = phase_timer + 1'b1;
                    else
                    begin
                        phase         = sms_pkg::PH_SAMPLE;
                        phase_timer   = '0;
                        samples_taken = '0;
                    end
                end
                if (phase == sms_pkg::PH_SAMPLE)
                begin
                    for (int c = 0; c < sms_pkg::COL_W; c++)
                        if (levels[c])
                            high_counts[c] = high_counts[c] + 1'b1;
                    samples_taken = samples_taken + 1'b1;
                    if (samples_taken >= target)
                    begin
                        if (hold_ticks > settle_ticks)
                        begin
                            phase       = sms_pkg::PH_HOLD;
                            phase_timer = '0;
                        end
                        else
                            finish = 1'b1;
                    end
                end
            end
            beat.row_index  = scan_row;
            beat.row_active = 1'b1;
            if (finish)
            begin
                voted = '0;
                for (int c = 0; c < sms_pkg::COL_W; c++)
                    voted[c] = (high_counts[c] > (target >> 1));
                if (stored_rows[scan_row] != voted)
                begin
                    stored_rows[scan_row] = voted;
                    beat.frame_changed    = 1'b1;
                    beat.changed_row      = scan_row;
                end
                beat.frame_complete = (scan_row == ROW_LAST);
                scan_row      = (scan_row == ROW_LAST) ? '0 : scan_row + 1'b1;
                phase         = sms_pkg::PH_SETTLE;
                phase_timer   = '0;
                samples_taken = '0;
                for (int c = 0; c < sms_pkg::COL_W; c++)
                    high_counts[c] = '0;
            end
            for (int r = 0; r < sms_pkg::ROWS_DEFAULT; r++)
                beat.frame[8*r +: 8] = stored_rows[r];
            expected_beats.push_back(beat);
        endfunction

        task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
            $display("%0t ns result beat %0d: %s is %0h, predicted %0h",
                     $time, beats_seen, field, got, want);
            mismatches++;
        endtask

        task check_beat(scan_beat_t got);
            scan_beat_t want;
            if (expected_beats.size() == 0)
                report_mismatch("unexpected beat, row_index", 64'(got.row_index), '0);
            else
            begin
                want = expected_beats.pop_front();
                if (got.row_index !== want.row_index)
                    report_mismatch("row_index", 64'(got.row_index),
                                    64'(want.row_index));
                if (got.row_active !== want.row_active)
                    report_mismatch("row_active", 64'(got.row_active),
                                    64'(want.row_active));
                if (got.frame_changed !== want.frame_changed)
                    report_mismatch("frame_changed", 64'(got.frame_changed),
                                    64'(want.frame_changed));
                if (got.changed_row !== want.changed_row)
                    report_mismatch("changed_row", 64'(got.changed_row),
                                    64'(want.changed_row));
                if (got.frame !== want.frame)
                    report_mismatch("frame", got.frame, want.frame);
                if (got.frame_complete !== want.frame_complete)
                    report_mismatch("frame_complete", 64'(got.frame_complete),
                                    64'(want.frame_complete));
            end
            beats_seen++;
        endtask
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [sms_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [sms_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [sms_pkg::COL_W-1:0]          col_levels = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic [sms_pkg::ROW_IDX_W-1:0]      row_index;
    logic                               row_active;
    logic                               frame_changed;
    logic [sms_pkg::ROW_IDX_W-1:0]      changed_row;
    logic [8*sms_pkg::COL_W-1:0]        frame;
    logic                               frame_complete;

    frame_tracker tracker;
    scan_beat_t   result_beat;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           pressure_on = 1'b0;
    bit           pressure_served = 1'b0;
    int           hold_left = 0;

    switch_matrix_scanner uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .col_levels     (col_levels),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .row_index      (row_index),
        .row_active     (row_active),
        .frame_changed  (frame_changed),
        .changed_row    (changed_row),
        .frame          (frame),
        .frame_complete (frame_complete)
    );

    always #4 clk = ~clk;

    assign result_beat = {row_index, row_active, frame_changed, changed_row,
                          frame, frame_complete};

    // Result side: check every accepted beat, then pick the next stall level.
    // One long hold-off during the pressure segment lets the input back up.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_beat(result_beat);
        if (pressure_on && !pressure_served)
        begin
            hold_left       = HOLD_OFF_CYCLES;
            pressure_served = 1'b1;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic send_tick(input logic [sms_pkg::COL_W-1:0] levels);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        col_levels <= levels;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_tick(levels);
    endtask

    task automatic write_reg(input logic [sms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sms_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_reg(idx, data);
    endtask

    task automatic set_timing(input logic [sms_pkg::CFG_DATA_W-1:0] settle,
                              input logic [sms_pkg::CFG_DATA_W-1:0] hold,
                              input logic [sms_pkg::CFG_DATA_W-1:0] samples,
                              input bit poke_spare);
        write_reg(sms_pkg::CFG_SETTLE, settle);
        write_reg(sms_pkg::CFG_HOLD, hold);
        write_reg(sms_pkg::CFG_SAMPLES, samples);
        if (poke_spare)
            write_reg(CFG_SPARE, 16'hFFFF);
        cfg_valid <= 1'b0;
    endtask

    // Every tick yields one beat, so an empty queue means the scanner is idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tracker.expected_beats.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    initial
    begin
        logic [39:0]               corner_levels;
        logic [sms_pkg::COL_W-1:0] pattern;
        logic [sms_pkg::COL_W-1:0] noise;
        tracker = new();
        corner_levels = {8'h55, 8'hAA, 8'h80, 8'h01, 8'h00};
        pattern = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 23;
        recv_idle_pct = 72;
        // A few ticks at reset timing leave row 0 part way through sampling,
        // then the zero timing below takes effect in the middle of that row.
        for (int k = 0; k < 6; k++)
            send_tick((k % 2) ? 8'h00 : 8'hFF);
        wait_idle();
        // Zero settle, zero hold and zero samples: every tick finishes a row.
        set_timing(16'd0, 16'd0, 16'd0, 1'b0);
        for (int k = 0; k < 18; k++)
            send_tick((k < 8) ? 8'hFF : corner_levels[8*(k % 5) +: 8]);
        wait_idle();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            send_idle_pct = (seg < 3) ? 23 : (seg < 6) ? 72 : 0;
            recv_idle_pct = (seg < 3) ? 72 : (seg < 6) ? 23 : 0;
            pressure_on   = (seg == PRESSURE_SEG);
            case (seg)
                0: set_timing(16'd0, 16'd0, 16'd15, 1'b0);
                1: set_timing(16'd2, 16'hFFFF, 16'd3, 1'b0);
                2: set_timing(16'hFFFF, 16'd0, 16'd1, 1'b0);
                3: set_timing(16'd1, 16'd3, 16'hA5F2, 1'b1);
                default: set_timing(16'($urandom_range(0, 6)),
                                    16'($urandom_range(0, 12)),
                                    16'($urandom_range(0, 65535)), 1'b0);
            endcase
            // A held switch pattern with sparse bounce on top of it.
            for (int k = 0; k < SEG_TICKS; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    pattern = sms_pkg::COL_W'($urandom);
                noise = '0;
                if ($urandom_range(0, 9) < 3)
                    noise = sms_pkg::COL_W'($urandom & $urandom & $urandom);
                send_tick(pattern ^ noise);
            end
            wait_idle();
        end

        repeat (5) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
